### rtl/heap_sort_engine_assert.svh
// ----------------------------------------------------------------------------
// Heap sort engine assertion macros
// Concurrent assertion wrappers; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_ENGINE_ASSERT_SVH
`define HEAP_SORT_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
// checked only while out of reset
`define HSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define HSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define HSE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/hse_pkg.sv
// ----------------------------------------------------------------------------
// Heap sort engine package
// Data word type and the compare unit's result struct.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] word_t;

  // which child wins the sift-down compare; neither set means the node stays
  typedef struct packed {
    logic take_l;
    logic take_r;
  } sel_t;

endpackage

### rtl/hse_store.sv
// ----------------------------------------------------------------------------
// Heap sort element store
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module hse_store
  import hse_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  word_t         wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output word_t         rdata_a,
  output word_t         rdata_b
);

  word_t mem [DEPTH];
  word_t rd_a_r;
  word_t rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

### rtl/hse_cmp.sv
// ----------------------------------------------------------------------------
// Heap sort compare unit
// Picks the largest of a node and its in-heap children for one sift step.
// ----------------------------------------------------------------------------
module hse_cmp
  import hse_pkg::*;
#(
  parameter int CW = 8
) (
  input  word_t         node_v,
  input  word_t         left_v,
  input  word_t         right_v,
  input  logic [CW-1:0] left_idx,
  input  logic [CW-1:0] right_idx,
  input  logic [CW-1:0] heap_sz,
  output sel_t          sel
);

  logic l_ok;
  logic r_ok;
  logic l_gt_n;
  logic r_gt_n;
  logic r_gt_l;

  assign l_ok   = left_idx < heap_sz;
  assign r_ok   = right_idx < heap_sz;
  assign l_gt_n = left_v > node_v;
  assign r_gt_n = right_v > node_v;
  assign r_gt_l = right_v > left_v;

  // right wins only if it beats both; ties keep the earlier candidate
  always_comb begin
    sel.take_r = r_ok && r_gt_l && r_gt_n;
    sel.take_l = !sel.take_r && l_ok && l_gt_n;
  end

endmodule

### rtl/heap_sort_engine.sv
// ----------------------------------------------------------------------------
// Heap sort engine
// Collects a set of signed words, heap sorts it in place, streams it out.
// ----------------------------------------------------------------------------
// Usage:
//   Input: one beat per cycle while busy is low, taken when start is high.
//   in_value is stored; in_last_item closes the set and starts the sort.
//   Beats past MAX_ITEMS are discarded and flag the whole set as dropped.
//   Sort: heap build, then N-1 extractions, each a sift-down run by one
//   compare unit against a two-read, one-write store. A sift first
//   fetches the node (or root and tail), then descends one heap level per
//   compare step and finally settles the travelling value into the hole;
//   the store's single write port paces each level.
//   Output: N result beats on consecutive cycles, out_valid high for one
//   cycle each, ascending order, out_last_out on the final beat, out_dropped
//   on every beat of an overflowed set. The receiver cannot stall; results
//   must be taken as they come. busy falls as the final beat is shown, so a
//   new set may begin loading during the final output beat.
//   Reset (synchronous, active low) empties the set and idles the block;
//   store contents are not cleared and need not be.
// ----------------------------------------------------------------------------
module heap_sort_engine
  import hse_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  word_t in_value,
  input  logic  in_last_item,
  output logic  out_valid,
  output word_t out_sorted_value,
  output logic  out_last_out,
  output logic  out_dropped
);

`include "heap_sort_engine_assert.svh"

  localparam int NW = $clog2(MAX_ITEMS + 1);  // counts 0..MAX_ITEMS
  localparam int AW = $clog2(MAX_ITEMS);      // store address
  localparam int CW = AW + 2;                 // child index, may run past the store

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // loading beats
  localparam logic [2:0] S_INIT = 3'd1;  // set up heap build
  localparam logic [2:0] S_BRD  = 3'd2;  // build: read node
  localparam logic [2:0] S_BLD  = 3'd3;  // build: latch node, read children
  localparam logic [2:0] S_CMP  = 3'd4;  // sift-down level
  localparam logic [2:0] S_XRD  = 3'd5;  // extract: read root and tail
  localparam logic [2:0] S_XSW  = 3'd6;  // extract: root to tail, tail to sift
  localparam logic [2:0] S_EMIT = 3'd7;  // stream results

  logic [2:0]    state_r, state_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [NW-1:0] hs_r, hs_nxt;
  logic [NW-1:0] i_r, i_nxt;        // build: node+1; extract: heap size before swap
  logic [AW-1:0] node_r, node_nxt;  // hole being sifted
  word_t         nv_r, nv_nxt;      // value travelling down
  logic          phase_r, phase_nxt;  // 0 build, 1 extract
  logic [AW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_drop_r, out_drop_nxt;

  // store ports
  logic          we;
  logic [AW-1:0] waddr;
  word_t         wdata;
  logic [AW-1:0] ra;
  logic [AW-1:0] rb;
  word_t         rd_a;
  word_t         rd_b;

  // sift step
  logic [CW-1:0] lc, rc, big_lc, big_rc;
  logic [AW-1:0] big;
  word_t         big_v;
  sel_t          sel;
  logic          sift_done;

  hse_store #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign lc = {1'b0, node_r, 1'b1};
  assign rc = lc + CW'(1);

  hse_cmp #(
    .CW (CW)
  ) u_cmp (
    .node_v    (nv_r),
    .left_v    (rd_a),
    .right_v   (rd_b),
    .left_idx  (lc),
    .right_idx (rc),
    .heap_sz   (CW'(hs_r)),
    .sel       (sel)
  );

  assign sift_done = !sel.take_l && !sel.take_r;
  assign big       = sel.take_r ? rc[AW-1:0] : lc[AW-1:0];
  assign big_v     = sel.take_r ? rd_b : rd_a;
  assign big_lc    = {1'b0, big, 1'b1};
  assign big_rc    = big_lc + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    hs_nxt        = hs_r;
    i_nxt         = i_r;
    node_nxt      = node_r;
    nv_nxt        = nv_r;
    phase_nxt     = phase_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    out_drop_nxt  = out_drop_r;
    we            = 1'b0;
    waddr         = node_r;
    wdata         = nv_r;
    ra            = node_r;
    rb            = node_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (count_r < NW'(MAX_ITEMS)) begin
            we        = 1'b1;
            waddr     = count_r[AW-1:0];
            wdata     = in_value;
            count_nxt = count_r + NW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_item) begin
            state_nxt = S_INIT;
          end
        end
      end

      S_INIT: begin
        hs_nxt    = count_r;
        i_nxt     = count_r >> 1;
        phase_nxt = 1'b0;
        k_nxt     = '0;
        if ((count_r >> 1) == '0) begin
          state_nxt = S_EMIT;  // single element, nothing to order
        end else begin
          node_nxt  = AW'((count_r >> 1) - NW'(1));
          state_nxt = S_BRD;
        end
      end

      S_BRD: begin
        ra        = node_r;
        state_nxt = S_BLD;
      end

      S_BLD: begin
        nv_nxt    = rd_a;
        ra        = lc[AW-1:0];
        rb        = rc[AW-1:0];
        state_nxt = S_CMP;
      end

      S_CMP: begin
        we    = 1'b1;
        waddr = node_r;
        if (sift_done) begin
          wdata = nv_r;  // settle the travelling value into the hole
          if (!phase_r) begin
            if (i_r == NW'(1)) begin
              phase_nxt = 1'b1;
              i_nxt     = count_r;
              state_nxt = S_XRD;
            end else begin
              i_nxt     = i_r - NW'(1);
              node_nxt  = AW'(i_r - NW'(2));
              state_nxt = S_BRD;
            end
          end else begin
            if (i_r == NW'(2)) begin
              k_nxt     = '0;
              state_nxt = S_EMIT;
            end else begin
              i_nxt     = i_r - NW'(1);
              state_nxt = S_XRD;
            end
          end
        end else begin
          // larger child moves up, hole moves down, fetch its children
          wdata    = big_v;
          node_nxt = big;
          ra       = big_lc[AW-1:0];
          rb       = big_rc[AW-1:0];
        end
      end

      S_XRD: begin
        ra        = '0;
        rb        = AW'(i_r - NW'(1));
        state_nxt = S_XSW;
      end

      S_XSW: begin
        we        = 1'b1;
        waddr     = AW'(i_r - NW'(1));
        wdata     = rd_a;
        nv_nxt    = rd_b;
        hs_nxt    = i_r - NW'(1);
        node_nxt  = '0;
        ra        = AW'(1);
        rb        = AW'(2);
        state_nxt = S_CMP;
      end

      S_EMIT: begin
        ra            = k_r;
        out_valid_nxt = 1'b1;
        out_last_nxt  = (NW'(k_r) == count_r - NW'(1));
        out_drop_nxt  = ovf_r;
        k_nxt         = k_r + AW'(1);
        if (NW'(k_r) == count_r - NW'(1)) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          hs_nxt    = '0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      hs_r        <= '0;
      i_r         <= '0;
      phase_r     <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      hs_r        <= hs_nxt;
      i_r         <= i_nxt;
      phase_r     <= phase_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    nv_r       <= nv_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_sorted_value = rd_a;  // store read data lines up with the strobe
  assign out_last_out     = out_last_r;
  assign out_dropped      = out_drop_r;

  // ---- assertions ----
  // a closing beat always starts the sort
  `HSE_ASSERT(a_last_starts_sort, clk, rst_n, (start && !busy && in_last_item) |=> busy, "last beat did not start sort")
  // result beats of one set come back to back
  `HSE_ASSERT(a_emit_contiguous, clk, rst_n, (out_valid && !out_last_out) |=> out_valid, "gap in result stream")
  // last marker only rides on a result beat
  `HSE_ASSERT_ALWAYS(a_last_with_valid, clk, out_last_out |-> out_valid, "last marker without strobe")
  // heap and set bookkeeping stay within the store
  `HSE_ASSERT(a_sizes_in_range, clk, rst_n, (hs_r <= count_r) && (count_r <= NW'(MAX_ITEMS)), "size out of range")

endmodule

### verif/sorted_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted stream checker
// Watches the load and result channels of the heap sort engine. It keeps its
// own copy of the set being loaded and heap sorts it when the closing beat is
// taken. Each result beat is then checked against the oldest expected word.
// ----------------------------------------------------------------------------
module sorted_stream_checker
  import hse_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  busy,
  input  word_t in_value,
  input  logic  in_last_item,
  input  logic  out_valid,
  input  word_t out_sorted_value,
  input  logic  out_last_out,
  input  logic  out_dropped,
  output int    mismatches,
  output int    beats_due
);

  typedef struct packed {
    word_t value;
    logic  last_out;
    logic  dropped;
  } sorted_beat_t;

  word_t        set_words [MAX_ITEMS];
  int unsigned  set_fill;
  logic         set_overflow;
  sorted_beat_t due_beats [$];

  initial begin
    mismatches   = 0;
    beats_due    = 0;
    set_fill     = 0;
    set_overflow = 1'b0;
  end

  task automatic report_mismatch(input string what, input word_t want, input word_t got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // iterative sift-down within the first heap_n words
  function automatic void sift_word(input int unsigned top, input int unsigned heap_n);
    int unsigned node;
    int unsigned big;
    int unsigned lc;
    int unsigned rc;
    word_t       tmp;
    logic        done;
    node = top;
    done = 1'b0;
    while (!done) begin
      lc  = 2 * node + 1;
      rc  = 2 * node + 2;
      big = node;
      if (lc < heap_n && set_words[lc] > set_words[big]) big = lc;
      if (rc < heap_n && set_words[rc] > set_words[big]) big = rc;
      if (big == node) begin
        done = 1'b1;
      end else begin
        tmp             = set_words[node];
        set_words[node] = set_words[big];
        set_words[big]  = tmp;
        node            = big;
      end
    end
  endfunction

  function automatic void heap_sort_set();
    int unsigned n;
    word_t       tmp;
    n = set_fill;
    for (int unsigned i = n / 2; i > 0; i--) sift_word(i - 1, n);
    for (int unsigned i = n; i > 1; i--) begin
      tmp              = set_words[0];
      set_words[0]     = set_words[i - 1];
      set_words[i - 1] = tmp;
      sift_word(0, i - 1);
    end
  endfunction

  task automatic absorb_beat(input word_t v, input logic closes);
    sorted_beat_t b;
    if (set_fill < MAX_ITEMS) begin
      set_words[set_fill] = v;
      set_fill++;
    end else begin
      set_overflow = 1'b1;
    end
    if (closes) begin
      heap_sort_set();
      for (int unsigned k = 0; k < set_fill; k++) begin
        b.value    = set_words[k];
        b.last_out = (k + 1 == set_fill);
        b.dropped  = set_overflow;
        due_beats.push_back(b);
      end
      set_fill     = 0;
      set_overflow = 1'b0;
    end
  endtask

  task automatic check_result();
    sorted_beat_t want;
    if (due_beats.size() == 0) begin
      report_mismatch("unexpected result", '0, out_sorted_value);
    end else begin
      want = due_beats.pop_front();
      if (out_sorted_value !== want.value)
        report_mismatch("sorted_value", want.value, out_sorted_value);
      if (out_last_out !== want.last_out)
        report_mismatch("last_out", word_t'(want.last_out), word_t'(out_last_out));
      if (out_dropped !== want.dropped)
        report_mismatch("dropped", word_t'(want.dropped), word_t'(out_dropped));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      set_fill     = 0;
      set_overflow = 1'b0;
      due_beats.delete();
    end else begin
      if (out_valid) check_result();
      if (start && !busy) absorb_beat(in_value, in_last_item);
    end
    beats_due = due_beats.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sort engine testbench
// Loads sets of signed words into the engine and lets the sorted stream
// checker predict and compare the ascending output, set by set.
// ----------------------------------------------------------------------------
module tb;
  import hse_pkg::*;

  localparam int ITEMS_MAX     = 64;
  localparam int TARGET_BEATS  = 370;
  // covers every full-size sort plus the slowest sender gaps many
  // times over
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_LIMIT   = 20000;
  // longer than one full-size sort, so a stray late result still shows up
  localparam int SETTLE_CYCLES = 1200;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  word_t in_value;
  logic  in_last_item;
  logic  out_valid;
  word_t out_sorted_value;
  logic  out_last_out;
  logic  out_dropped;

  int mismatches;
  int beats_due;
  int cycle_count;
  int beats_sent;
  int sender_idle_pct;
  int set_index;

  heap_sort_engine #(
    .MAX_ITEMS(ITEMS_MAX)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_sorted_value(out_sorted_value),
    .out_last_out    (out_last_out),
    .out_dropped     (out_dropped)
  );

  sorted_stream_checker #(
    .MAX_ITEMS(ITEMS_MAX)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_sorted_value(out_sorted_value),
    .out_last_out    (out_last_out),
    .out_dropped     (out_dropped),
    .mismatches      (mismatches),
    .beats_due       (beats_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung engine or a lost result ends the run here
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Mostly full-range random words; some from a tiny pool so that equal
  // values land in one set, some at the signed extremes.
  function automatic word_t pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        return word_t'(int'($urandom_range(0, 6)) - 3);
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       return WORD_MAX;
          1:       return WORD_MIN;
          2:       return word_t'(-1);
          default: return '0;
        endcase
      end
      default: begin
        return word_t'($urandom);
      end
    endcase
  endfunction

  // Small sets dominate (big ones are slow to sort); the tail goes past the
  // store depth so overflow shows up now and then.
  function automatic int unsigned pick_set_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 92) return $urandom_range(9, 24);
    return $urandom_range(25, ITEMS_MAX + 6);
  endfunction

  // Called just after a falling edge; returns just after the falling edge
  // that follows the accepting rising edge. start is assigned once per
  // falling edge, so back-to-back beats keep it high without a glitch.
  task automatic push_beat(input word_t v, input logic closes);
    // sender idle rate by phase: light, then heavy, then none
    if (beats_sent < TARGET_BEATS / 3)          sender_idle_pct = 13;
    else if (beats_sent < 2 * TARGET_BEATS / 3) sender_idle_pct = 87;
    else                                        sender_idle_pct = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      // idle cycle: garbage on the data lines must be ignored
      start        = 1'b0;
      in_value     = word_t'($urandom);
      in_last_item = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    start        = 1'b1;
    in_value     = v;
    in_last_item = closes;
    // busy is read at the edge itself, before the engine's own update lands
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic push_set(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_beat(pick_word(), i + 1 == n);
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_value        = '0;
    in_last_item    = 1'b0;
    beats_sent      = 0;
    sender_idle_pct = 13;
    set_index       = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single-word sets at both signed extremes
    push_beat(WORD_MAX, 1'b1);
    push_beat(WORD_MIN, 1'b1);
    // extremes, sign boundary and duplicates mixed in one set
    push_beat('0, 1'b0);
    push_beat(word_t'(-1), 1'b0);
    push_beat(word_t'(1), 1'b0);
    push_beat(WORD_MIN, 1'b0);
    push_beat(WORD_MAX, 1'b0);
    push_beat(word_t'(-1), 1'b0);
    push_beat(WORD_MAX, 1'b0);
    push_beat(WORD_MIN, 1'b1);
    // two words, already descending
    push_beat(word_t'(5), 1'b0);
    push_beat(word_t'(-5), 1'b1);
    // alternating bit patterns and a run of equal values
    push_beat(word_t'(32'hAAAA_AAAA), 1'b0);
    push_beat(word_t'(32'h5555_5555), 1'b0);
    push_beat(word_t'(32'hFFFF_FFFF), 1'b0);
    push_beat('0, 1'b0);
    push_beat(word_t'(7), 1'b0);
    push_beat(word_t'(7), 1'b0);
    push_beat(word_t'(7), 1'b1);

    // Random sets. A few sizes are pinned: exactly full store, one over so
    // the closing beat itself is dropped, and several over.
    while (beats_sent < TARGET_BEATS) begin
      case (set_index)
        0:       push_set(ITEMS_MAX);
        1:       push_set(ITEMS_MAX + 1);
        6:       push_set(ITEMS_MAX + 6);
        default: push_set(pick_set_size());
      endcase
      set_index++;
    end
    start = 1'b0;

    // drain: wait for the last set to come out, then watch for strays
    for (int w = 0; w < DRAIN_LIMIT && beats_due != 0; w++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0 && beats_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
